// File: hw/rtl/fbfs_pkg.sv
// Shared types and codes for the free block fit selector.
package fbfs_pkg;

	// Operation codes carried by a request.
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_ALLOC = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// Fit policy codes held in the configuration register.
	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_BEST  = 2'd1;
	localparam logic [1:0] POL_NEXT  = 2'd2;
	localparam logic [1:0] POL_WORST = 2'd3;

	typedef struct packed {
		logic [1:0]  operation;
		logic [5:0]  slot_index;
		logic [31:0] block_size;
		logic        block_free;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [5:0]  found_index;
		logic [31:0] found_size;
	} res_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic prep;
		logic issue;
		logic commit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_alloc;
		logic empty;
		logic last_issue;
	} stat_t;

endpackage

// File: hw/rtl/fbfs_ctrl.sv
// Sequencing state machine for the free block fit selector.
module fbfs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  fbfs_pkg::stat_t stat,
	output fbfs_pkg::cmd_t  cmd,
	output logic            busy
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_PREP   = 5'b00010,
		S_SCAN   = 5'b00100,
		S_DRAIN  = 5'b01000,
		S_COMMIT = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				if (stat.is_alloc && !stat.empty) begin
					state_d = S_SCAN;
				end else begin
					state_d = S_COMMIT;
				end
			end
			S_SCAN: begin
				if (stat.last_issue) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign cmd.capture = (state_q == S_IDLE) && start;
	assign cmd.prep    = (state_q == S_PREP);
	assign cmd.issue   = (state_q == S_SCAN);
	assign cmd.commit  = (state_q == S_COMMIT);

endmodule

// File: hw/rtl/fbfs_datapath.sv
// Descriptor table, scan pointer, candidate tracking and result register.
module fbfs_datapath #(
	parameter int TABLE_DEPTH = 64,
	parameter int SIZE_BITS   = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  fbfs_pkg::req_t  req,
	input  logic            cfg_valid,
	input  logic [1:0]      cfg_data,
	input  fbfs_pkg::cmd_t  cmd,
	output fbfs_pkg::stat_t stat,
	output logic            done,
	output fbfs_pkg::res_t  res
);

	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int WIDE_W = ((IDX_W > 6) ? IDX_W : 6) + 1;
	localparam int SZW    = (SIZE_BITS > 32) ? SIZE_BITS : 32;

	logic [1:0]             policy_q;
	fbfs_pkg::req_t         req_q;
	logic [SIZE_BITS-1:0]   size_mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] free_q;
	logic [CNT_W-1:0]       count_q;
	logic [IDX_W-1:0]       resume_idx_q;
	logic                   resume_valid_q;

	logic [1:0]             pol_q;
	logic                   resumed_q;
	logic [SIZE_BITS-1:0]   want_q;
	logic [IDX_W-1:0]       pos_q;
	logic [CNT_W-1:0]       left_q;

	logic [SIZE_BITS-1:0]   rd_data_s1;
	logic [IDX_W-1:0]       rd_pos_s1;
	logic                   rd_vld_s1;

	logic                   have_q;
	logic [IDX_W-1:0]       best_pos_q;
	logic [SIZE_BITS-1:0]   best_size_q;

	logic                   done_q;
	fbfs_pkg::res_t         res_q;

	logic [WIDE_W-1:0]      slot_wide;
	logic                   slot_ok;
	logic [IDX_W-1:0]       wr_idx;
	logic [SIZE_BITS-1:0]   req_size;
	logic                   mem_we;
	logic                   resume_ok;
	logic [IDX_W-1:0]       start_pos;
	logic [IDX_W-1:0]       pos_next;
	logic                   fit;
	logic                   better;
	logic                   take;
	logic [WIDE_W-1:0]      pick_wide;
	logic [SZW-1:0]         pick_size_wide;
	logic [SZW-1:0]         in_size_wide;

	// Request fields mapped onto the table's index and size widths.
	assign slot_wide    = WIDE_W'(req_q.slot_index);
	assign slot_ok      = slot_wide < WIDE_W'(TABLE_DEPTH);
	assign wr_idx       = slot_wide[IDX_W-1:0];
	assign in_size_wide = SZW'(req_q.block_size);
	assign req_size     = in_size_wide[SIZE_BITS-1:0];
	assign mem_we       = cmd.commit && (req_q.operation == fbfs_pkg::OP_WRITE) && slot_ok;

	// Next fit resumes after the previous pick only while that pick is still inside the walk.
	assign resume_ok = resume_valid_q && (CNT_W'(resume_idx_q) < count_q);
	assign start_pos = (resume_ok && (policy_q == fbfs_pkg::POL_NEXT)
		&& (CNT_W'(resume_idx_q) + CNT_W'(1) < count_q)) ? resume_idx_q + IDX_W'(1) : '0;

	assign pos_next = (CNT_W'(pos_q) + CNT_W'(1) >= count_q) ? '0 : pos_q + IDX_W'(1);

	assign stat.is_alloc   = (req_q.operation == fbfs_pkg::OP_ALLOC);
	assign stat.empty      = (count_q == '0);
	assign stat.last_issue = (left_q == CNT_W'(1));

	// Candidate compare for the entry read in the previous cycle.
	assign fit = rd_vld_s1 && free_q[rd_pos_s1] && (rd_data_s1 >= want_q);

	always_comb begin
		case (pol_q) inside
			fbfs_pkg::POL_FIRST, fbfs_pkg::POL_NEXT: better = 1'b0;
			fbfs_pkg::POL_BEST:                      better = rd_data_s1 <= best_size_q;
			default:                                 better = rd_data_s1 >= best_size_q;
		endcase
	end

	assign take = fit && (!have_q || better);

	assign pick_wide      = WIDE_W'(best_pos_q);
	assign pick_size_wide = SZW'(best_size_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			size_mem[wr_idx] <= req_size;
		end
		rd_data_s1 <= size_mem[pos_q];
		rd_pos_s1  <= pos_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		if (cmd.prep) begin
			pol_q     <= policy_q;
			resumed_q <= resume_ok;
			want_q    <= req_size;
			pos_q     <= start_pos;
			left_q    <= count_q;
		end else if (cmd.issue) begin
			pos_q  <= pos_next;
			left_q <= left_q - CNT_W'(1);
		end
		if (take) begin
			best_pos_q  <= rd_pos_s1;
			best_size_q <= rd_data_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q       <= fbfs_pkg::POL_FIRST;
			free_q         <= '0;
			count_q        <= '0;
			resume_idx_q   <= '0;
			resume_valid_q <= 1'b0;
			rd_vld_s1      <= 1'b0;
			have_q         <= 1'b0;
			done_q         <= 1'b0;
		end else begin
			if (cfg_valid) begin
				policy_q <= cfg_data;
			end
			rd_vld_s1 <= cmd.issue;
			done_q    <= cmd.commit;
			if (cmd.prep) begin
				have_q <= 1'b0;
			end else if (take) begin
				have_q <= 1'b1;
			end
			if (cmd.commit) begin
				unique case (req_q.operation)
					fbfs_pkg::OP_WRITE: begin
						if (slot_ok) begin
							free_q[wr_idx] <= req_q.block_free;
							if (CNT_W'(wr_idx) >= count_q) begin
								count_q <= CNT_W'(wr_idx) + CNT_W'(1);
							end
						end
					end
					fbfs_pkg::OP_CLEAR: begin
						free_q         <= '0;
						count_q        <= '0;
						resume_valid_q <= 1'b0;
					end
					fbfs_pkg::OP_ALLOC: begin
						if (have_q) begin
							free_q[best_pos_q] <= 1'b0;
						end
						if (pol_q == fbfs_pkg::POL_NEXT) begin
							if (resumed_q) begin
								if (have_q) begin
									resume_idx_q <= best_pos_q;
								end
							end else begin
								resume_valid_q <= have_q;
								resume_idx_q   <= have_q ? best_pos_q : '0;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Result register: only a successful allocation reports a block.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (stat.is_alloc && have_q) begin
				res_q.found       <= 1'b1;
				res_q.found_index <= pick_wide[5:0];
				res_q.found_size  <= pick_size_wide[31:0];
			end else begin
				res_q <= '0;
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

`ifndef SYNTHESIS
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for more than one cycle");

	a_resume_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		resume_valid_q |-> (CNT_W'(resume_idx_q) < count_q))
		else $error("valid resume point lies outside the walk");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("slot count beyond table depth");

	a_hit_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && res_q.found) |-> !free_q[best_pos_q])
		else $error("allocated block still marked free");
`endif

endmodule

// File: hw/rtl/free_block_fit_selector.sv
// Top level of the free block fit selector: descriptor table searched under a fit policy.
//
// Usage:
//   Requests enter on req with start; a request transfers at a clock edge where start is
//   high and busy is low. A request writes one descriptor, clears the table, or asks for
//   a free block of at least block_size under the policy held in the configuration
//   register (first, best, next or worst fit).
//   Every request gives exactly one result on res, marked by done for one cycle. The
//   receiver cannot hold results off; done is never high in two consecutive cycles.
//   The policy register is written through cfg_valid/cfg_data; cfg_ready is always high.
//   Write it only while busy is low and no result is pending.
// Timing:
//   A write, clear, unknown operation or allocation on an empty table passes from its
//   setup state straight to the commit state. Other allocations walk the N live
//   descriptors (N = slot count) one per cycle through the size memory's single read
//   port, then pass a drain state before the commit state. busy drops in the cycle done
//   shows, so the next request can transfer as soon as done shows, not before.
// Reset:
//   arst_n clears the free flags, the slot count, the resume point and the policy
//   (first fit) at once; no clearing pass is needed.
module free_block_fit_selector #(
	parameter int TABLE_DEPTH = 64,
	parameter int SIZE_BITS   = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  fbfs_pkg::req_t req,
	output logic           done,
	output fbfs_pkg::res_t res,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [1:0]     cfg_data
);

	fbfs_pkg::cmd_t  cmd;
	fbfs_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	fbfs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	fbfs_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.SIZE_BITS   (SIZE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.done      (done),
		.res       (res)
	);

endmodule
